// File: hdl/spq_pkg.sv
// Package for the sorted priority queue: request/response payloads,
// command and status codes, sequencer states. No dependencies.
package spq_pkg;

  localparam int unsigned KeyBits   = 32;
  localparam int unsigned CountBits = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } spq_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } spq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_CMP,
    S_TOP,
    S_TOPCAP,
    S_DONE
  } spq_state_e;

  typedef struct packed {
    spq_cmd_e           cmd;
    logic [KeyBits-1:0] key;
  } spq_req_t;

  typedef struct packed {
    logic [KeyBits-1:0]   top_key;
    logic [CountBits-1:0] count;
    logic                 is_empty;
    spq_status_e          status;
  } spq_rsp_t;

endpackage

// File: hdl/spq_stream_if.sv
// Valid/ready channel carrying one request or response payload.
// Payload type comes from spq_pkg at instantiation.
interface spq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hdl/sorted_priority_queue.sv
// Sorted max-priority queue: keys held descending in a circular RAM list.
// An insert shifts each stored key smaller than or equal to the new one down one place;
// a removal advances the head and reads the new top key if one is left; full/empty requests are dropped.
// One request at a time; each shift step is a RAM read followed by a compare/write.
// Reset empties the queue (count 0, head 0) and selects unsigned compare; RAM is not cleared.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_stream_if.sink    req_i,
  spq_stream_if.source  rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import spq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [KEY_WIDTH-1:0] SignBit = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  spq_state_e           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 signed_q;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [KEY_WIDTH-1:0] top_q, top_d;
  spq_status_e          status_q, status_d;
  spq_rsp_t             rsp_q, rsp_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [KEY_WIDTH-1:0] flip;
  logic                 key_ge;

  spq_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign flip   = signed_q ? SignBit : '0;
  assign key_ge = (key_q ^ flip) >= (ram_rdata ^ flip);

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    idx_d       = idx_q;
    key_d       = key_q;
    top_d       = top_q;
    status_d    = status_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = phys(head_q, idx_q);
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = phys(head_q, idx_q - AW'(1));

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d    = KEY_WIDTH'(req_i.data.key);
          idx_d    = AW'(count_q);
          status_d = STAT_OK;
          if (req_i.data.cmd == CMD_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = STAT_FULL;
              state_d  = S_DONE;
            end else begin
              state_d = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STAT_EMPTY;
              state_d  = S_DONE;
            end else begin
              head_d  = phys(head_q, AW'(1));
              count_d = count_q - CW'(1);
              state_d = (count_q == CW'(1)) ? S_DONE : S_TOP;
            end
          end
        end
      end
      S_INS: begin
        if (idx_q == '0) begin
          ram_we  = 1'b1;
          top_d   = key_q;
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        if (key_ge) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - AW'(1);
          state_d   = S_INS;
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end
      end
      S_TOP: begin
        ram_re    = 1'b1;
        ram_raddr = head_q;
        state_d   = S_TOPCAP;
      end
      S_TOPCAP: begin
        top_d   = ram_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d    = 1'b1;
          rsp_d.top_key  = (count_q == '0) ? '0 : KeyBits'(top_q);
          rsp_d.count    = CountBits'(count_q);
          rsp_d.is_empty = (count_q == '0);
          rsp_d.status   = status_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      signed_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        signed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    top_q    <= top_d;
    status_q <= status_d;
    rsp_q    <= rsp_d;
  end

endmodule

// File: sim/tb.sv
// Testbench for sorted_priority_queue: a queue-fed request driver, a response
// monitor and an in-bench sorted-list predictor compared field by field.
// Depends on hdl/spq_pkg.sv, hdl/spq_stream_if.sv and hdl/sorted_priority_queue.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int unsigned PhaseCount  = 7;
  localparam int unsigned PhaseItems  = 230;
  localparam int unsigned DrainCycles = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_wdata_i;

  spq_stream_if #(.T(spq_req_t)) req_if ();
  spq_stream_if #(.T(spq_rsp_t)) rsp_if ();

  sorted_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  spq_req_t           req_backlog [$];
  spq_rsp_t           rsp_expected [$];
  logic [KeyBits-1:0] model_keys [Depth];
  int unsigned        model_count;
  bit                 signed_mode;
  bit                 steady;
  int unsigned        errors;
  int unsigned        send_gap;
  int unsigned        stall_left;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [KeyBits-1:0] rank(logic [KeyBits-1:0] k);
    return signed_mode ? {~k[KeyBits-1], k[KeyBits-2:0]} : k;
  endfunction

  function automatic spq_rsp_t apply_request(spq_req_t r);
    spq_rsp_t    res;
    int unsigned pos;
    int unsigned i;
    res.status = STAT_OK;
    if (r.cmd == CMD_INSERT) begin
      if (model_count >= Depth) begin
        res.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < model_count && rank(r.key) < rank(model_keys[pos])) pos++;
        for (i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
        model_keys[pos] = r.key;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        for (i = 0; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
        model_count--;
      end
    end
    res.top_key  = (model_count > 0) ? model_keys[0] : '0;
    res.count    = CountBits'(model_count);
    res.is_empty = (model_count == 0);
    return res;
  endfunction

  // mostly short gaps, a few long ones, none in steady phases
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [KeyBits-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return {1'($urandom_range(0, 1)), 28'd0, 3'($urandom_range(0, 7))};
      default: return $urandom;
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch on %s, got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  task automatic push_req(spq_cmd_e c, logic [KeyBits-1:0] k);
    spq_req_t r;
    r.cmd = c;
    r.key = k;
    req_backlog.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (req_backlog.size() != 0 || rsp_expected.size() != 0 || req_if.valid)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_sign_mode(bit mode);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    signed_mode = mode;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      send_gap     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) rsp_expected.push_back(apply_request(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          req_if.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (req_backlog.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= req_backlog.pop_front();
          send_gap     <= idle_len();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    spq_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_expected.size() == 0) begin
          note_mismatch("unexpected response", rsp_if.data.top_key, '0);
        end else begin
          want = rsp_expected.pop_front();
          if (rsp_if.data.top_key !== want.top_key)
            note_mismatch("top_key", rsp_if.data.top_key, want.top_key);
          if (rsp_if.data.count !== want.count)
            note_mismatch("count", rsp_if.data.count, want.count);
          if (rsp_if.data.is_empty !== want.is_empty)
            note_mismatch("is_empty", rsp_if.data.is_empty, want.is_empty);
          if (rsp_if.data.status !== want.status)
            note_mismatch("status", rsp_if.data.status, want.status);
        end
      end
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left   <= idle_len();
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned bias;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_sign_mode(1'b0);

    // empty removal, extremes, duplicate, fill to full, drop on full, drain past empty
    push_req(CMD_REMOVE, '1);
    push_req(CMD_INSERT, '0);
    push_req(CMD_INSERT, '1);
    push_req(CMD_INSERT, 32'h8000_0000);
    push_req(CMD_INSERT, 32'h7FFF_FFFF);
    push_req(CMD_INSERT, 32'h8000_0000);
    for (n = 0; n < Depth - 5; n++) push_req(CMD_INSERT, pick_key());
    push_req(CMD_INSERT, '1);
    push_req(CMD_INSERT, '0);
    for (n = 0; n < Depth + 2; n++) push_req(CMD_REMOVE, $urandom);
    wait_drained();

    for (phase = 0; phase < PhaseCount; phase++) begin
      steady = (phase == 2 || phase == 5);
      set_sign_mode(phase % 2 == 0);
      bias = 50;
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       bias = 20;
            1:       bias = 50;
            default: bias = 85;
          endcase
        end
        push_req(($urandom_range(0, 99) < bias) ? CMD_INSERT : CMD_REMOVE, pick_key());
      end
      // leave the queue empty before the compare mode changes
      for (n = 0; n < Depth; n++) push_req(CMD_REMOVE, $urandom);
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
